/* src/ccs_pkg.sv */
// Shared types, constants and calendar helpers for the calendar clock block.
// Used by the tick logic, the timestamp sequencer and the top level.
// No dependencies.
`default_nettype none

package ccs_pkg;

   // Field widths of the calendar.
   localparam int YEAR_W   = 8;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int ZONE_W   = 4;
   localparam int STAMP_W  = 32;
   localparam int FYEAR_W  = 12;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 72;

   // Request kinds carried on req_tuser.
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_SET  = 1'b1;

   localparam logic [FYEAR_W-1:0]  BASE_YEAR   = 12'd2000;
   localparam logic [FYEAR_W-1:0]  EPOCH_YEAR  = 12'd1970;
   localparam logic [FYEAR_W-1:0]  NOLEAP_2100 = 12'd2100;
   localparam logic [FYEAR_W-1:0]  NOLEAP_2200 = 12'd2200;
   localparam logic [8:0]          DAYS_PER_YEAR  = 9'd365;
   localparam logic [16:0]         SEC_PER_DAY    = 17'd86400;
   localparam logic [11:0]         SEC_PER_HOUR   = 12'd3600;
   localparam logic [5:0]          SEC_PER_MINUTE = 6'd60;
   localparam logic [SECOND_W-1:0] LAST_SECOND    = 6'd59;
   localparam logic [MINUTE_W-1:0] LAST_MINUTE    = 6'd59;
   localparam logic [HOUR_W-1:0]   LAST_HOUR      = 5'd23;
   localparam logic [MONTH_W:0]    MONTHS_PER_YEAR = 5'd12;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } cal_type;

   localparam cal_type CAL_RESET = '{year: 8'd17, month: 4'd1, day: 5'd1,
                                     hour: 5'd0, minute: 6'd0, second: 6'd0};

   typedef struct packed {
      logic                start;
      cal_type             cal;
      logic [ZONE_W-1:0]   zone;
   } stamp_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [STAMP_W-1:0]  stamp;
   } stamp_stat_type;

   // Gregorian rule, valid for the years 1970 through 2255 that the block can reach.
   function automatic logic leap_year(input logic [FYEAR_W-1:0] year);
      return (year[1:0] == 2'b00) && (year != NOLEAP_2100) && (year != NOLEAP_2200);
   endfunction

   // Any month number outside January..December counts as a 31-day month.
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      unique case (month)
         MONTH_FEB:                               len = 5'd28 + DAY_W'(leap);
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         default:                                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

/* src/calendar_clock_with_epoch_seconds_unit.sv */
// Top level of the calendar clock with Unix seconds count.
// Depends on ccs_pkg, ccs_tick and ccs_stamp.
//
//   channel  dir  tdata                                   tuser
//   req_     in   year/month/day/hour/minute/second/zone  kind: 0 tick, 1 set
//   rsp_     out  calendar and 32-bit seconds count       -
//
// A tick request's response is valid in the cycle after it is accepted. A set
// request's response is valid once the sequencer has walked the years and months
// before the set date with the shared adder and then finished the day and time.
// req_tready is low while a set is in progress and while a response waits.
// Reset loads 2017-01-01 00:00:00 and a seconds count of zero.
`default_nettype none

module calendar_clock_with_epoch_seconds_unit
   import ccs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // set_year[7:0], set_month[11:8], set_day[16:12], set_hour[21:17],
   // set_minute[27:22], set_second[33:28], zone_hours[37:34], zeros[39:38]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // mode[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // year_out[7:0], month_out[11:8], day_out[16:12], hour_out[21:17],
   // minute_out[27:22], second_out[33:28], epoch_seconds[65:34], zeros[71:66]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   cal_type             cal_ff;
   logic [STAMP_W-1:0]  count_ff;
   logic                rsp_valid_ff;

   cal_type             tick_cal;
   cal_type             set_cal;
   stamp_req_type       stamp_req;
   stamp_stat_type      stamp_stat;
   logic                req_fire;
   logic                rsp_fire;

   assign req_tready = !stamp_stat.busy && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;

   assign set_cal.year   = req_tdata[7:0];
   assign set_cal.month  = req_tdata[11:8];
   assign set_cal.day    = req_tdata[16:12];
   assign set_cal.hour   = req_tdata[21:17];
   assign set_cal.minute = req_tdata[27:22];
   assign set_cal.second = req_tdata[33:28];

   assign stamp_req.start = req_fire && (req_tuser == MODE_SET);
   assign stamp_req.cal   = set_cal;
   assign stamp_req.zone  = req_tdata[37:34];

   ccs_tick u_tick (
      .cal_i (cal_ff),
      .cal_o (tick_cal)
   );

   ccs_stamp u_stamp (
      .clock  (clock),
      .reset  (reset),
      .req_i  (stamp_req),
      .stat_o (stamp_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff       <= CAL_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((req_fire && (req_tuser == MODE_TICK)) || stamp_stat.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            if (req_tuser == MODE_TICK) begin
               cal_ff       <= tick_cal;
               count_ff     <= count_ff + 32'd1;
            end else begin
               // The calendar is stored as given; the count follows when the walk ends.
               cal_ff <= set_cal;
            end
         end
         if (stamp_stat.done) begin
            count_ff     <= stamp_stat.stamp;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, count_ff, cal_ff.second, cal_ff.minute, cal_ff.hour,
                        cal_ff.day, cal_ff.month, cal_ff.year};

endmodule

`default_nettype wire

/* src/ccs_tick.sv */
// One-second advance of the calendar with Gregorian month lengths.
// Depends on ccs_pkg.
`default_nettype none

module ccs_tick
   import ccs_pkg::*;
(
   input  cal_type cal_i,
   output cal_type cal_o
);

   logic               sec_wrap;
   logic               min_wrap;
   logic               hour_wrap;
   logic               day_roll;
   logic               month_roll;
   logic [DAY_W-1:0]   len;
   logic [DAY_W:0]     day_sum;
   logic [MONTH_W:0]   month_sum;
   logic [DAY_W:0]     day_left;
   logic [MONTH_W:0]   month_left;

   assign sec_wrap   = cal_i.second >= LAST_SECOND;
   assign min_wrap   = sec_wrap && (cal_i.minute >= LAST_MINUTE);
   assign hour_wrap  = min_wrap && (cal_i.hour >= LAST_HOUR);
   assign len        = month_days(cal_i.month, leap_year(BASE_YEAR + FYEAR_W'(cal_i.year)));
   assign day_sum    = {1'b0, cal_i.day} + 6'd1;
   assign day_roll   = hour_wrap && (day_sum > {1'b0, len});
   assign month_sum  = {1'b0, cal_i.month} + 5'd1;
   assign month_roll = day_roll && (month_sum > MONTHS_PER_YEAR);
   // An oversized day loses one month length only, landing early in the next month.
   assign day_left   = day_sum - {1'b0, len};
   assign month_left = month_sum - MONTHS_PER_YEAR;

   always_comb begin
      cal_o        = cal_i;
      cal_o.second = sec_wrap ? '0 : cal_i.second + 6'd1;
      if (sec_wrap) begin
         cal_o.minute = min_wrap ? '0 : cal_i.minute + 6'd1;
      end
      if (min_wrap) begin
         cal_o.hour = hour_wrap ? '0 : cal_i.hour + 5'd1;
      end
      if (hour_wrap) begin
         cal_o.day = day_roll ? day_left[DAY_W-1:0] : day_sum[DAY_W-1:0];
      end
      if (day_roll) begin
         cal_o.month = month_roll ? month_left[MONTH_W-1:0] : month_sum[MONTH_W-1:0];
      end
      if (month_roll) begin
         cal_o.year = cal_i.year + 8'd1;
      end
   end

endmodule

`default_nettype wire

/* src/ccs_stamp.sv */
// Unix timestamp sequencer: one shared 32-bit add/subtract unit walks the
// years and months since 1970, then scales to seconds. Depends on ccs_pkg.
`default_nettype none

module ccs_stamp
   import ccs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  stamp_req_type  req_i,
   output stamp_stat_type stat_o
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_YEARS, ST_MONTHS, ST_DAY, ST_SCALE,
      ST_HOUR, ST_MINUTE, ST_SECOND, ST_ZONE
   } state_type;

   state_type            state_ff;
   logic                 done_ff;
   logic [STAMP_W-1:0]   acc_ff;
   logic [FYEAR_W-1:0]   year_ff;
   logic [FYEAR_W-1:0]   target_ff;
   logic                 leap_ff;
   logic [MONTH_W-1:0]   month_ff;
   logic [MONTH_W-1:0]   month_lim_ff;
   logic [DAY_W-1:0]     day_ff;
   logic [HOUR_W-1:0]    hour_ff;
   logic [MINUTE_W-1:0]  minute_ff;
   logic [SECOND_W-1:0]  second_ff;
   logic [ZONE_W-1:0]    zone_ff;

   logic [STAMP_W-1:0]   operand;
   logic                 subtract;
   logic [STAMP_W-1:0]   acc_in;
   logic [48:0]          product;
   logic [16:0]          hour_secs;
   logic [11:0]          minute_secs;
   logic [15:0]          zone_secs;
   logic [FYEAR_W-1:0]   set_year;
   logic [MONTH_W-1:0]   month_lim;

   assign hour_secs   = hour_ff * SEC_PER_HOUR;
   assign minute_secs = minute_ff * SEC_PER_MINUTE;
   assign zone_secs   = zone_ff * SEC_PER_HOUR;
   assign product     = acc_ff * SEC_PER_DAY;
   assign set_year    = BASE_YEAR + FYEAR_W'(req_i.cal.year);

   // Months wholly before the loaded one; above December all twelve count.
   always_comb begin
      if (req_i.cal.month == '0) begin
         month_lim = '0;
      end else if (req_i.cal.month > MONTH_DEC) begin
         month_lim = MONTH_DEC;
      end else begin
         month_lim = req_i.cal.month - 4'd1;
      end
   end

   always_comb begin
      operand  = '0;
      subtract = 1'b0;
      unique case (state_ff)
         ST_YEARS:  operand = STAMP_W'(DAYS_PER_YEAR) + STAMP_W'(leap_year(year_ff));
         ST_MONTHS: operand = STAMP_W'(month_days(month_ff, leap_ff));
         ST_DAY:    operand = STAMP_W'(day_ff);
         ST_HOUR:   operand = STAMP_W'(hour_secs);
         ST_MINUTE: operand = STAMP_W'(minute_secs);
         ST_SECOND: operand = STAMP_W'(second_ff);
         ST_ZONE: begin
            operand  = STAMP_W'(zone_secs);
            subtract = 1'b1;
         end
         default:   operand = '0;
      endcase
   end

   assign acc_in = subtract ? acc_ff - operand : acc_ff + operand;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_i.start) begin
                  // Starting at minus one folds the day-of-month offset in.
                  acc_ff       <= '1;
                  year_ff      <= EPOCH_YEAR;
                  target_ff    <= set_year;
                  leap_ff      <= leap_year(set_year);
                  month_ff     <= MONTH_JAN;
                  month_lim_ff <= month_lim;
                  day_ff       <= req_i.cal.day;
                  hour_ff      <= req_i.cal.hour;
                  minute_ff    <= req_i.cal.minute;
                  second_ff    <= req_i.cal.second;
                  zone_ff      <= req_i.zone;
                  state_ff     <= ST_YEARS;
               end
            end
            ST_YEARS: begin
               if (year_ff == target_ff) begin
                  state_ff <= ST_MONTHS;
               end else begin
                  acc_ff  <= acc_in;
                  year_ff <= year_ff + 12'd1;
               end
            end
            ST_MONTHS: begin
               if (month_ff > month_lim_ff) begin
                  state_ff <= ST_DAY;
               end else begin
                  acc_ff   <= acc_in;
                  month_ff <= month_ff + 4'd1;
               end
            end
            ST_DAY: begin
               acc_ff   <= acc_in;
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               acc_ff   <= product[STAMP_W-1:0];
               state_ff <= ST_HOUR;
            end
            ST_HOUR: begin
               acc_ff   <= acc_in;
               state_ff <= ST_MINUTE;
            end
            ST_MINUTE: begin
               acc_ff   <= acc_in;
               state_ff <= ST_SECOND;
            end
            ST_SECOND: begin
               acc_ff   <= acc_in;
               state_ff <= ST_ZONE;
            end
            ST_ZONE: begin
               acc_ff   <= acc_in;
               done_ff  <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign stat_o.busy  = (state_ff != ST_IDLE) || done_ff;
   assign stat_o.done  = done_ff;
   assign stat_o.stamp = acc_ff;

endmodule

`default_nettype wire

/* src/ccs_checker.sv */
// Port-level checks for the calendar clock top level, attached by bind.
// Depends on calendar_clock_with_epoch_seconds_unit's port list only.
`default_nettype none

module ccs_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire [39:0] req_tdata,
   input wire        req_tuser,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [71:0] rsp_tdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !(req_tvalid && req_tready))
      else $error("request taken while a response is stalled");

   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=>
         rsp_tvalid && (rsp_tdata[65:34] == $past(rsp_tdata[65:34]) + 32'd1))
      else $error("tick did not advance the seconds count by one");

   a_set_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready && !rsp_tvalid)
      else $error("set request finished or released the input too early");

endmodule

bind calendar_clock_with_epoch_seconds_unit ccs_checker u_ccs_checker (.*);

`default_nettype wire

/* bench/tb_calendar_clock_with_epoch_seconds_unit.sv */
// Self-checking bench for the calendar clock with Unix seconds count: directed
// rows at the calendar and counter edges, then random set-and-tick sequences.
// Depends on ccs_pkg and calendar_clock_with_epoch_seconds_unit.
module tb_calendar_clock_with_epoch_seconds_unit
   import ccs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              mode;
      cal_type           cal;
      logic [ZONE_W-1:0] zone;
   } clock_req_type;

   typedef struct packed {
      cal_type            cal;
      logic [STAMP_W-1:0] count;
   } clock_reading_type;

   typedef struct {
      clock_req_type     req;
      bit                known;
      clock_reading_type want;
   } script_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Model of the block's state, advanced once per accepted request.
   cal_type            model_cal;
   logic [STAMP_W-1:0] model_count;

   clock_reading_type pending_readings[$];
   script_row_type    script[$];
   int                mismatches = 0;
   int                readings_seen = 0;
   bit                steady = 1'b0;
   clock_reading_type got_reading, want_reading;

   calendar_clock_with_epoch_seconds_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   function automatic bit leap_gregorian(int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   // Any month number outside 1..12 is taken as 31 days long.
   function automatic int unsigned days_in(int unsigned y2000, int unsigned m);
      if (m < 1 || m > 12) return 31;
      if (m == 2) return 28 + leap_gregorian(y2000 + 2000);
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
   endfunction

   function automatic void step_one_second();
      int unsigned len, sec, mnt, hr, dy, mo;
      len = days_in(model_cal.year, model_cal.month);
      sec = model_cal.second + 1;
      mnt = model_cal.minute;
      hr  = model_cal.hour;
      dy  = model_cal.day;
      mo  = model_cal.month;
      model_count = model_count + 1;
      if (sec > 59) begin
         sec = 0;
         mnt++;
         if (mnt > 59) begin
            mnt = 0;
            hr++;
            if (hr > 23) begin
               hr = 0;
               dy++;
               // An oversized day loses one month length and lands early next month.
               if (dy > len) begin
                  dy -= len;
                  mo++;
                  if (mo > 12) begin
                     mo -= 12;
                     model_cal.year = model_cal.year + 1;
                  end
               end
            end
         end
      end
      model_cal.second = 6'(sec);
      model_cal.minute = 6'(mnt);
      model_cal.hour   = 5'(hr);
      model_cal.day    = 5'(dy);
      model_cal.month  = 4'(mo);
   endfunction

   function automatic logic [STAMP_W-1:0] stamp_of(cal_type c, logic [ZONE_W-1:0] zone);
      logic [31:0] days, secs;
      int unsigned y, m, last_month;
      days = 0;
      for (y = 1970; y < 32'(c.year) + 2000; y++)
         days = days + 365 + leap_gregorian(y);
      // Month 0 adds no month days; months above 12 add the whole year.
      last_month = (c.month == 0) ? 0 : c.month - 1;
      if (last_month > 12) last_month = 12;
      for (m = 1; m <= last_month; m++)
         days = days + days_in(c.year, m);
      days = days + c.day - 1;
      secs = days * 86400 + c.hour * 3600 + c.minute * 60 + c.second - zone * 3600;
      return secs;
   endfunction

   function automatic clock_reading_type clock_after(clock_req_type r);
      clock_reading_type res;
      if (r.mode == MODE_TICK) begin
         step_one_second();
      end else begin
         model_cal   = r.cal;
         model_count = stamp_of(r.cal, r.zone);
      end
      res.cal   = model_cal;
      res.count = model_count;
      return res;
   endfunction

   function automatic clock_req_type random_request(logic mode);
      clock_req_type r;
      r.mode       = mode;
      r.cal.year   = 8'($urandom_range(255));
      r.cal.month  = 4'($urandom_range(15));
      r.cal.day    = 5'($urandom_range(31));
      r.cal.hour   = 5'($urandom_range(31));
      r.cal.minute = 6'($urandom_range(63));
      r.cal.second = 6'($urandom_range(63));
      r.zone       = 4'($urandom_range(15));
      return r;
   endfunction

   function automatic void add_row(logic mode, int yr, int mo, int dy, int hr, int mi, int se,
                                   int zn, bit known = 0, int wyr = 0, int wmo = 0,
                                   int wdy = 0, int whr = 0, int wmi = 0, int wse = 0,
                                   logic [31:0] wcount = 0);
      script_row_type row;
      row.req.mode  = mode;
      row.req.cal   = '{8'(yr), 4'(mo), 5'(dy), 5'(hr), 6'(mi), 6'(se)};
      row.req.zone  = 4'(zn);
      row.known     = known;
      row.want.cal  = '{8'(wyr), 4'(wmo), 5'(wdy), 5'(whr), 6'(wmi), 6'(wse)};
      row.want.count = wcount;
      script.push_back(row);
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      mismatches++;
      $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
   endtask

   // Offers one request from the falling edge on and returns at the falling edge
   // after it was taken.
   task automatic offer_request(input clock_req_type r, input bit known,
                                input clock_reading_type want);
      clock_reading_type predicted;
      while (!steady && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.mode;
      req_tdata  <= REQ_TDATA_W'({r.zone, r.cal.second, r.cal.minute, r.cal.hour,
                                  r.cal.day, r.cal.month, r.cal.year});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = clock_after(r);
      pending_readings.push_back(known ? want : predicted);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         readings_seen++;
         got_reading.cal.year   = rsp_tdata[7:0];
         got_reading.cal.month  = rsp_tdata[11:8];
         got_reading.cal.day    = rsp_tdata[16:12];
         got_reading.cal.hour   = rsp_tdata[21:17];
         got_reading.cal.minute = rsp_tdata[27:22];
         got_reading.cal.second = rsp_tdata[33:28];
         got_reading.count      = rsp_tdata[65:34];
         if (pending_readings.size() == 0) begin
            note_mismatch("response with nothing pending", got_reading.count, 0);
         end else begin
            want_reading = pending_readings.pop_front();
            if (got_reading.cal.year !== want_reading.cal.year)
               note_mismatch("year", got_reading.cal.year, want_reading.cal.year);
            if (got_reading.cal.month !== want_reading.cal.month)
               note_mismatch("month", got_reading.cal.month, want_reading.cal.month);
            if (got_reading.cal.day !== want_reading.cal.day)
               note_mismatch("day", got_reading.cal.day, want_reading.cal.day);
            if (got_reading.cal.hour !== want_reading.cal.hour)
               note_mismatch("hour", got_reading.cal.hour, want_reading.cal.hour);
            if (got_reading.cal.minute !== want_reading.cal.minute)
               note_mismatch("minute", got_reading.cal.minute, want_reading.cal.minute);
            if (got_reading.cal.second !== want_reading.cal.second)
               note_mismatch("second", got_reading.cal.second, want_reading.cal.second);
            if (got_reading.count !== want_reading.count)
               note_mismatch("epoch seconds", got_reading.count, want_reading.count);
         end
      end
   end

   // Response side: random stalls, plus one long hold-off that backs the block up.
   initial begin
      int hold_left;
      bit held;
      rsp_tready = 1'b0;
      hold_left  = 0;
      held       = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held && readings_seen >= 300) begin
            held      = 1'b1;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 6);
         end
      end
   end

   initial begin
      clock_req_type     r;
      clock_reading_type unused;
      int                sent, burst, pick;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_TICK;
      unused     = '0;
      model_cal  = '{8'd17, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0};
      model_count = '0;

      //      mode       yr   mo  dy  hr  mi  se  zn  typed-in result
      add_row(MODE_TICK,  0,  0,  0,  0,  0,  0,  0, 1, 17, 1, 1, 0, 0, 1, 32'd1);
      // A tick ignores whatever the set fields hold.
      add_row(MODE_TICK, 255, 15, 31, 31, 63, 63, 15, 1, 17, 1, 1, 0, 0, 2, 32'd2);
      add_row(MODE_SET,   0,  1,  1,  0,  0,  0,  0, 1, 0, 1, 1, 0, 0, 0, 32'd946684800);
      add_row(MODE_SET,  38,  1, 19,  3, 14,  8,  0, 1, 38, 1, 19, 3, 14, 8, 32'h8000_0000);
      add_row(MODE_SET, 106,  2,  7,  6, 28, 15,  0, 1, 106, 2, 7, 6, 28, 15, 32'hFFFF_FFFF);
      // The seconds count wraps to zero here.
      add_row(MODE_TICK,  0,  0,  0,  0,  0,  0,  0, 1, 106, 2, 7, 6, 28, 16, 32'd0);
      add_row(MODE_SET, 100,  2, 28, 23, 59, 59,  0);   // 2100 is not a leap year
      add_row(MODE_TICK,  0,  0,  0,  0,  0,  0,  0);
      add_row(MODE_SET,   0,  2, 28, 23, 59, 59,  0);   // 2000 is a leap year
      add_row(MODE_TICK,  0,  0,  0,  0,  0,  0,  0);
      add_row(MODE_SET, 255, 12, 31, 23, 59, 59, 14);   // last year rolls over to 2000
      add_row(MODE_TICK,  0,  0,  0,  0,  0,  0,  0);
      add_row(MODE_SET,   1,  2, 31, 23, 59, 59,  3);   // oversized day in February
      add_row(MODE_TICK,  0,  0,  0,  0,  0,  0,  0);
      add_row(MODE_SET,  10, 15, 31, 23, 59, 59,  0);   // month above 12 carried into the next year
      add_row(MODE_TICK,  0,  0,  0,  0,  0,  0,  0);
      add_row(MODE_SET,   7,  0,  5, 23, 59, 59,  1);   // month 0 on a tick
      add_row(MODE_TICK,  0,  0,  0,  0,  0,  0,  0);
      add_row(MODE_SET,  20, 13,  1, 31, 63, 63,  2);   // time fields above their maximum
      add_row(MODE_TICK,  0,  0,  0,  0,  0,  0,  0);
      add_row(MODE_SET,   0,  0,  0,  0,  0,  0,  0);   // day 0 and month 0 on a set
      add_row(MODE_SET, 255, 15, 31, 31, 63, 63, 15);
      add_row(MODE_TICK,  0,  0,  0,  0,  0,  0,  0);
      add_row(MODE_SET,  17,  1,  1,  0,  0,  0, 15);   // zone pushes the count back

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) offer_request(script[i].req, script[i].known, script[i].want);

      // Random part: mostly sets just before a rollover, followed by ticks across it.
      sent = script.size();
      while (sent < 450) begin
         steady = (sent >= 150 && sent < 230);
         pick = $urandom_range(99);
         if (pick < 80) begin
            r = random_request(MODE_SET);
            if ($urandom_range(9) != 0) begin
               r.cal.month = 4'($urandom_range(12, 1));
               r.cal.day   = 5'(days_in(r.cal.year, r.cal.month) - $urandom_range(1, 0));
            end
            if ($urandom_range(9) != 0) r.cal.hour = 5'd23;
            if ($urandom_range(9) != 0) r.cal.minute = 6'd59;
            r.cal.second = 6'($urandom_range(59, 50));
            burst = $urandom_range(12, 1);
         end else if (pick < 90) begin
            r = random_request(MODE_SET);
            burst = $urandom_range(3, 1);
         end else begin
            r = random_request(MODE_TICK);
            burst = $urandom_range(20, 5);
         end
         offer_request(r, 1'b0, unused);
         sent++;
         repeat (burst) begin
            offer_request(random_request(MODE_TICK), 1'b0, unused);
            sent++;
         end
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (pending_readings.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_calendar_clock_with_epoch_seconds_unit OK");
      end else begin
         $display("tb_calendar_clock_with_epoch_seconds_unit NOT OK");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("tb_calendar_clock_with_epoch_seconds_unit NOT OK");
      $finish;
   end

endmodule
